/* design/max_subarray_divide_conquer_core_macros.svh */
// Assertion macros for the top-level core, which checks its own logic with them.
`ifndef MAX_SUBARRAY_DIVIDE_CONQUER_CORE_MACROS_SVH
`define MAX_SUBARRAY_DIVIDE_CONQUER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MSDC_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MSDC_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* design/msdc_pkg.sv */
`default_nettype none
package msdc_pkg;

   localparam int MAX_LEN_DEF    = 1024;
   localparam int DATA_WIDTH_DEF = 32;
   localparam int VALUE_W        = 32;
   localparam int INDEX_OUT_W    = 10;
   localparam int SUM_OUT_W      = 32;
   localparam int STATUS_W       = 2;
   localparam int RSP_DATA_W     = 56;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK       = 2'd0,
      STATUS_OVERFLOW = 2'd1,
      STATUS_TOO_LONG = 2'd2
   } msdc_status_type;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_VISIT,
      ST_LEAF,
      ST_SCAN,
      ST_JOIN,
      ST_DONE
   } msdc_state_type;

   // Progress of one range on the frame stack.
   typedef enum logic [1:0] {
      PH_NEW,
      PH_LEFT,
      PH_RIGHT
   } msdc_phase_type;

endpackage
`default_nettype wire

/* design/msdc_store.sv */
`default_nettype none
module msdc_store #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule
`default_nettype wire

/* design/msdc_alu.sv */
`default_nettype none
module msdc_alu #(
   parameter int WIDTH = 32
) (
   input  wire logic [WIDTH-1:0] a,
   input  wire logic [WIDTH-1:0] b,
   input  wire logic [WIDTH-1:0] c,
   output logic      [WIDTH-1:0] sum,
   output logic                  ovf,
   output logic                  gt
);
   // One wrapping adder with signed overflow, and a compare of its sum.
   always_comb begin
      sum = a + b;
      ovf = (a[WIDTH-1] == b[WIDTH-1]) && (sum[WIDTH-1] != a[WIDTH-1]);
      gt  = $signed(sum) > $signed(c);
   end
endmodule
`default_nettype wire

/* design/msdc_seq.sv */
`default_nettype none
module msdc_seq #(
   parameter int MAX_LEN    = 1024,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_accept,
   input  wire logic [DATA_WIDTH-1:0]         in_value,
   input  wire logic                          in_last,
   input  wire logic                          out_free,
   output logic                               ready,
   output logic                               busy,
   output logic                               st_wr_en,
   output logic      [$clog2(MAX_LEN)-1:0]    st_wr_addr,
   output logic      [DATA_WIDTH-1:0]         st_wr_data,
   output logic      [$clog2(MAX_LEN)-1:0]    st_rd_addr,
   input  wire logic [DATA_WIDTH-1:0]         st_rd_data,
   output logic                               done,
   output logic      [$clog2(MAX_LEN)-1:0]    done_lo,
   output logic      [$clog2(MAX_LEN)-1:0]    done_hi,
   output logic      [DATA_WIDTH-1:0]         done_sum,
   output msdc_pkg::msdc_status_type          done_status
);
   import msdc_pkg::*;

   localparam int IDX_W = $clog2(MAX_LEN);
   localparam int CNT_W = $clog2(MAX_LEN + 1);
   localparam int DEPTH = IDX_W + 1;
   localparam int SP_W  = $clog2(DEPTH + 1);
   localparam int TOP_W = $clog2(DEPTH);

   msdc_state_type state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic long_ff, long_in;
   logic ovf_ff, ovf_in;
   logic [SP_W-1:0] sp_ff, sp_in;

   logic [IDX_W-1:0]      f_lo_ff [DEPTH], f_lo_in [DEPTH];
   logic [IDX_W-1:0]      f_hi_ff [DEPTH], f_hi_in [DEPTH];
   msdc_phase_type        f_ph_ff [DEPTH], f_ph_in [DEPTH];
   logic [IDX_W-1:0]      f_llo_ff [DEPTH], f_llo_in [DEPTH];
   logic [IDX_W-1:0]      f_lhi_ff [DEPTH], f_lhi_in [DEPTH];
   logic [DATA_WIDTH-1:0] f_lsum_ff [DEPTH], f_lsum_in [DEPTH];

   logic [IDX_W-1:0]      ret_lo_ff, ret_lo_in, ret_hi_ff, ret_hi_in;
   logic [DATA_WIDTH-1:0] ret_sum_ff, ret_sum_in;

   logic [IDX_W-1:0]      p_ff, p_in, end_ff, end_in, q_ff, q_in;
   logic                  issue_ff, issue_in, pend_ff, pend_in;
   logic                  first_ff, first_in, right_ff, right_in;
   logic [DATA_WIDTH-1:0] run_ff, run_in, best_ff, best_in, lsum_ff, lsum_in;
   logic [IDX_W-1:0]      bidx_ff, bidx_in, lidx_ff, lidx_in;

   logic [TOP_W-1:0]      top;
   logic [TOP_W-1:0]      push;
   logic [IDX_W-1:0]      t_lo, t_hi, mid;
   logic [IDX_W:0]        lo_plus_hi;
   msdc_phase_type        t_ph;
   logic                  is_leaf, last_frame, too_long, scan_end, scan_ovf;
   logic [DATA_WIDTH-1:0] alu_a, alu_b, alu_sum;
   logic                  alu_ovf, alu_gt;

   msdc_alu #(.WIDTH(DATA_WIDTH)) u_alu (
      .a(alu_a), .b(alu_b), .c(best_ff), .sum(alu_sum), .ovf(alu_ovf), .gt(alu_gt)
   );

   always_comb begin
      top        = TOP_W'(sp_ff - SP_W'(1));
      push       = sp_ff[TOP_W-1:0];
      t_lo       = f_lo_ff[top];
      t_hi       = f_hi_ff[top];
      t_ph       = f_ph_ff[top];
      lo_plus_hi = {1'b0, t_lo} + {1'b0, t_hi};
      mid        = lo_plus_hi[IDX_W:1];
      is_leaf    = (t_lo == t_hi);
      last_frame = (sp_ff == SP_W'(1));
      too_long   = long_ff || (count_ff == CNT_W'(MAX_LEN));
      scan_end   = pend_ff && (q_ff == end_ff);
      scan_ovf   = pend_ff && !first_ff && alu_ovf;
      if (state_ff == ST_JOIN) begin
         alu_a = lsum_ff;
         alu_b = best_ff;
      end else begin
         alu_a = run_ff;
         alu_b = st_rd_data;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_LOAD: begin
            if (in_accept && in_last && !too_long) state_in = ST_VISIT;
         end
         ST_VISIT: begin
            if (is_leaf) state_in = ST_LEAF;
            else if (t_ph == PH_RIGHT) state_in = ST_SCAN;
         end
         ST_LEAF, ST_JOIN: begin
            state_in = last_frame ? ST_DONE : ST_VISIT;
         end
         ST_SCAN: begin
            if (scan_ovf) state_in = ST_DONE;
            else if (scan_end && right_ff) state_in = ST_JOIN;
         end
         ST_DONE: begin
            if (out_free) state_in = ST_LOAD;
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      long_in  = long_ff;
      ovf_in   = ovf_ff;
      sp_in    = sp_ff;
      f_lo_in  = f_lo_ff;
      f_hi_in  = f_hi_ff;
      f_ph_in  = f_ph_ff;
      f_llo_in = f_llo_ff;
      f_lhi_in = f_lhi_ff;
      f_lsum_in = f_lsum_ff;
      ret_lo_in = ret_lo_ff;
      ret_hi_in = ret_hi_ff;
      ret_sum_in = ret_sum_ff;
      p_in = p_ff;
      end_in = end_ff;
      q_in = q_ff;
      issue_in = issue_ff;
      pend_in = pend_ff;
      first_in = first_ff;
      right_in = right_ff;
      run_in = run_ff;
      best_in = best_ff;
      bidx_in = bidx_ff;
      lsum_in = lsum_ff;
      lidx_in = lidx_ff;
      ready = (state_ff == ST_LOAD) && out_free;
      busy = (state_ff != ST_LOAD);
      st_wr_en = 1'b0;
      st_wr_addr = count_ff[IDX_W-1:0];
      st_wr_data = in_value;
      st_rd_addr = t_lo;
      done = 1'b0;
      done_lo = '0;
      done_hi = '0;
      done_sum = '0;
      done_status = STATUS_OK;

      unique case (state_ff)
         ST_LOAD: begin
            if (in_accept) begin
               if (count_ff < CNT_W'(MAX_LEN)) begin
                  st_wr_en = 1'b1;
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  long_in = 1'b1;
               end
               if (in_last) begin
                  count_in = '0;
                  long_in = 1'b0;
                  if (too_long) begin
                     done = 1'b1;
                     done_status = STATUS_TOO_LONG;
                  end else begin
                     // The whole array becomes the first range.
                     sp_in = SP_W'(1);
                     f_lo_in[0] = '0;
                     f_hi_in[0] = count_ff[IDX_W-1:0];
                     f_ph_in[0] = PH_NEW;
                     ovf_in = 1'b0;
                  end
               end
            end
         end
         ST_VISIT: begin
            if (!is_leaf) begin
               case (t_ph)
                  PH_NEW: begin
                     f_ph_in[top] = PH_LEFT;
                     f_lo_in[push] = t_lo;
                     f_hi_in[push] = mid;
                     f_ph_in[push] = PH_NEW;
                     sp_in = sp_ff + SP_W'(1);
                  end
                  PH_LEFT: begin
                     // The left half has returned; keep it and descend right.
                     f_llo_in[top] = ret_lo_ff;
                     f_lhi_in[top] = ret_hi_ff;
                     f_lsum_in[top] = ret_sum_ff;
                     f_ph_in[top] = PH_RIGHT;
                     f_lo_in[push] = mid + IDX_W'(1);
                     f_hi_in[push] = t_hi;
                     f_ph_in[push] = PH_NEW;
                     sp_in = sp_ff + SP_W'(1);
                  end
                  default: begin
                     p_in = mid;
                     end_in = t_lo;
                     issue_in = 1'b1;
                     pend_in = 1'b0;
                     first_in = 1'b1;
                     right_in = 1'b0;
                  end
               endcase
            end
         end
         ST_LEAF: begin
            ret_lo_in = t_lo;
            ret_hi_in = t_lo;
            ret_sum_in = st_rd_data;
            sp_in = sp_ff - SP_W'(1);
         end
         ST_SCAN: begin
            st_rd_addr = p_ff;
            pend_in = issue_ff;
            q_in = p_ff;
            if (issue_ff) begin
               if (p_ff == end_ff) issue_in = 1'b0;
               else if (right_ff) p_in = p_ff + IDX_W'(1);
               else p_in = p_ff - IDX_W'(1);
            end
            if (pend_ff) begin
               first_in = 1'b0;
               if (first_ff) begin
                  run_in = st_rd_data;
                  best_in = st_rd_data;
                  bidx_in = q_ff;
               end else begin
                  run_in = alu_sum;
                  if (alu_ovf) ovf_in = 1'b1;
                  if (alu_gt) begin
                     best_in = alu_sum;
                     bidx_in = q_ff;
                  end
               end
               if (scan_end && !right_ff) begin
                  // Left side done: start the right side at mid + 1.
                  lsum_in = best_in;
                  lidx_in = bidx_in;
                  right_in = 1'b1;
                  p_in = mid + IDX_W'(1);
                  end_in = t_hi;
                  issue_in = 1'b1;
                  first_in = 1'b1;
                  pend_in = 1'b0;
               end
            end
         end
         ST_JOIN: begin
            // Left wins ties, then right, then the crossing span.
            if ($signed(f_lsum_ff[top]) >= $signed(ret_sum_ff) &&
                $signed(f_lsum_ff[top]) >= $signed(alu_sum)) begin
               ret_lo_in = f_llo_ff[top];
               ret_hi_in = f_lhi_ff[top];
               ret_sum_in = f_lsum_ff[top];
            end else if (!($signed(ret_sum_ff) >= $signed(alu_sum))) begin
               ret_lo_in = lidx_ff;
               ret_hi_in = bidx_ff;
               ret_sum_in = alu_sum;
            end
            sp_in = sp_ff - SP_W'(1);
         end
         ST_DONE: begin
            if (out_free) begin
               done = 1'b1;
               if (ovf_ff) begin
                  done_status = STATUS_OVERFLOW;
               end else begin
                  done_lo = ret_lo_ff;
                  done_hi = ret_hi_ff;
                  done_sum = ret_sum_ff;
               end
               ovf_in = 1'b0;
            end
         end
         default: begin
            sp_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
         count_ff <= '0;
         long_ff  <= 1'b0;
         ovf_ff   <= 1'b0;
         sp_ff    <= '0;
         issue_ff <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         long_ff  <= long_in;
         ovf_ff   <= ovf_in;
         sp_ff    <= sp_in;
         issue_ff <= issue_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      f_lo_ff <= f_lo_in;
      f_hi_ff <= f_hi_in;
      f_ph_ff <= f_ph_in;
      f_llo_ff <= f_llo_in;
      f_lhi_ff <= f_lhi_in;
      f_lsum_ff <= f_lsum_in;
      ret_lo_ff <= ret_lo_in;
      ret_hi_ff <= ret_hi_in;
      ret_sum_ff <= ret_sum_in;
      p_ff <= p_in;
      end_ff <= end_in;
      q_ff <= q_in;
      first_ff <= first_in;
      right_ff <= right_in;
      run_ff <= run_in;
      best_ff <= best_in;
      bidx_ff <= bidx_in;
      lsum_ff <= lsum_in;
      lidx_ff <= lidx_in;
   end
endmodule
`default_nettype wire

/* design/max_subarray_divide_conquer_core.sv */
// Channel  | Direction | Handshake              | Contents
// req      | in        | req_tvalid/req_tready  | one array word, tlast on the final one
// rsp      | out       | rsp_tvalid/rsp_tready  | span indices and sum, status in tuser
//
// Loading takes one word per cycle while rsp has room. Then one shared adder walks
// the store: a leaf is read and returned, an inner range descends into its halves,
// scans its crossing span on each side and joins, bound by one read port.
// Reset is synchronous and empties the store count and the search stacks.
// While a result waits on rsp and is not taken, no new word is taken.
`default_nettype none
`include "max_subarray_divide_conquer_core_macros.svh"
module max_subarray_divide_conquer_core #(
   parameter int MAX_LEN    = msdc_pkg::MAX_LEN_DEF,
   parameter int DATA_WIDTH = msdc_pkg::DATA_WIDTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // [31:0] value
   input  wire logic        req_tlast,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [55:0]      rsp_tdata,   // [9:0] low_index, [19:10] high_index,
                                         // [51:20] best_sum, [55:52] zero
   output logic [1:0]       rsp_tuser    // [1:0] status
);
   import msdc_pkg::*;

   localparam int IDX_W = $clog2(MAX_LEN);

   logic                  accept, out_free, busy, done;
   logic                  st_wr_en;
   logic [IDX_W-1:0]      st_wr_addr, st_rd_addr, done_lo, done_hi;
   logic [DATA_WIDTH-1:0] st_wr_data, st_rd_data, done_sum, value_ext;
   msdc_status_type       done_status;
   logic [VALUE_W+DATA_WIDTH-1:0]  value_wide;
   logic [IDX_W+INDEX_OUT_W-1:0]   lo_wide, hi_wide;
   logic [DATA_WIDTH+SUM_OUT_W-1:0] sum_wide;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [INDEX_OUT_W-1:0] rsp_lo_ff, rsp_lo_in, rsp_hi_ff, rsp_hi_in;
   logic [SUM_OUT_W-1:0]   rsp_sum_ff, rsp_sum_in;
   logic [STATUS_W-1:0]    rsp_status_ff, rsp_status_in;

   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign value_wide = {{DATA_WIDTH{req_tdata[VALUE_W-1]}}, req_tdata};
   assign value_ext  = value_wide[DATA_WIDTH-1:0];

   msdc_store #(.DEPTH(MAX_LEN), .WIDTH(DATA_WIDTH)) u_store (
      .clock(clock), .wr_en(st_wr_en), .wr_addr(st_wr_addr), .wr_data(st_wr_data),
      .rd_addr(st_rd_addr), .rd_data(st_rd_data)
   );

   msdc_seq #(.MAX_LEN(MAX_LEN), .DATA_WIDTH(DATA_WIDTH)) u_seq (
      .clock(clock), .reset(reset), .in_accept(accept), .in_value(value_ext),
      .in_last(req_tlast), .out_free(out_free), .ready(req_tready), .busy(busy),
      .st_wr_en(st_wr_en), .st_wr_addr(st_wr_addr), .st_wr_data(st_wr_data),
      .st_rd_addr(st_rd_addr), .st_rd_data(st_rd_data), .done(done),
      .done_lo(done_lo), .done_hi(done_hi), .done_sum(done_sum),
      .done_status(done_status)
   );

   always_comb begin
      lo_wide       = {{INDEX_OUT_W{1'b0}}, done_lo};
      hi_wide       = {{INDEX_OUT_W{1'b0}}, done_hi};
      sum_wide      = {{SUM_OUT_W{done_sum[DATA_WIDTH-1]}}, done_sum};
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_lo_in     = rsp_lo_ff;
      rsp_hi_in     = rsp_hi_ff;
      rsp_sum_in    = rsp_sum_ff;
      rsp_status_in = rsp_status_ff;
      if (done) begin
         rsp_valid_in  = 1'b1;
         rsp_lo_in     = lo_wide[INDEX_OUT_W-1:0];
         rsp_hi_in     = hi_wide[INDEX_OUT_W-1:0];
         rsp_sum_in    = sum_wide[SUM_OUT_W-1:0];
         rsp_status_in = done_status;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_lo_ff     <= rsp_lo_in;
      rsp_hi_ff     <= rsp_hi_in;
      rsp_sum_ff    <= rsp_sum_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_sum_ff, rsp_hi_ff, rsp_lo_ff};
   assign rsp_tuser  = rsp_status_ff;

   `MSDC_ASSERT_SAME(a_no_take_while_busy, clock, reset, busy, !req_tready, "word taken during search")
   `MSDC_ASSERT_SAME(a_done_has_room, clock, reset, done, out_free, "result would overwrite a waiting one")
   `MSDC_ASSERT_NEXT(a_error_zero, clock, reset, done && (done_status != STATUS_OK), rsp_sum_ff == '0 && rsp_lo_ff == '0 && rsp_hi_ff == '0, "error result carries data")
endmodule
`default_nettype wire

/* tb/max_subarray_divide_conquer_core_test.sv */
`timescale 1ns / 1ps
module max_subarray_divide_conquer_core_test;
   import msdc_pkg::*;

   typedef struct {
      int lo;
      int hi;
      int sum;
   } span_type;

   typedef struct {
      logic [55:0] data;
      logic [1:0]  status;
   } span_result_type;

   class span_scoreboard;
      int              words[$];
      bit              too_long;
      bit              scan_ovf;
      span_result_type spans_due[$];
      int              errors;

      function int add_checked(int a, int b);
         int r;
         r = a + b;
         if ((a < 0) == (b < 0) && (r < 0) != (a < 0)) scan_ovf = 1;
         return r;
      endfunction

      function span_type cross_span(int lo, int hi, int mid);
         span_type c;
         int run, left, right;
         run = words[mid];
         left = run;
         c.lo = mid;
         for (int i = mid; i > lo; i--) begin
            run = add_checked(run, words[i-1]);
            if (run > left) begin
               left = run;
               c.lo = i - 1;
            end
         end
         run = words[mid+1];
         right = run;
         c.hi = mid + 1;
         for (int i = mid + 2; i <= hi; i++) begin
            run = add_checked(run, words[i]);
            if (run > right) begin
               right = run;
               c.hi = i;
            end
         end
         // The final join wraps without raising the overflow status.
         c.sum = right + left;
         return c;
      endfunction

      function span_type best_span(int lo, int hi);
         span_type l, r, c;
         int mid;
         if (lo == hi) begin
            l.lo = lo;
            l.hi = hi;
            l.sum = words[lo];
            return l;
         end
         mid = (lo + hi) / 2;
         l = best_span(lo, mid);
         r = best_span(mid + 1, hi);
         c = cross_span(lo, hi, mid);
         if (l.sum >= r.sum && l.sum >= c.sum) return l;
         if (r.sum >= c.sum && r.sum >= l.sum) return r;
         return c;
      endfunction

      function void note_word(logic [31:0] value, logic last);
         span_type b;
         span_result_type e;
         if (words.size() < MAX_LEN_DEF) words.push_back(int'(value));
         else too_long = 1;
         if (!last) return;
         b = '{0, 0, 0};
         e.status = STATUS_OK;
         if (too_long) begin
            e.status = STATUS_TOO_LONG;
         end else begin
            scan_ovf = 0;
            b = best_span(0, words.size() - 1);
            if (scan_ovf) begin
               e.status = STATUS_OVERFLOW;
               b = '{0, 0, 0};
            end
         end
         e.data = {4'd0, b.sum[31:0], b.hi[9:0], b.lo[9:0]};
         spans_due.push_back(e);
         words.delete();
         too_long = 0;
      endfunction

      function void check_result(logic [55:0] data, logic [1:0] status);
         span_result_type e;
         if (spans_due.size() == 0) begin
            $error("result word with no expectation: data %h status %0d", data, status);
            errors++;
            return;
         end
         e = spans_due.pop_front();
         if (data[9:0] !== e.data[9:0]) begin
            $error("low_index: expected %0d, actual %0d", e.data[9:0], data[9:0]);
            errors++;
         end
         if (data[19:10] !== e.data[19:10]) begin
            $error("high_index: expected %0d, actual %0d", e.data[19:10], data[19:10]);
            errors++;
         end
         if (data[51:20] !== e.data[51:20]) begin
            $error("best_sum: expected %0d, actual %0d",
                   $signed(e.data[51:20]), $signed(data[51:20]));
            errors++;
         end
         if (data[55:52] !== 4'd0) begin
            $error("pad bits: expected 0, actual %h", data[55:52]);
            errors++;
         end
         if (status !== e.status) begin
            $error("status: expected %0d, actual %0d", e.status, status);
            errors++;
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [55:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   span_scoreboard sb;
   int send_idle_pct;
   int recv_stall_pct;
   int hold_left;
   int sent_words;

   max_subarray_divide_conquer_core i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("CHECKS FAILED");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) sb.note_word(req_tdata, req_tlast);
         if (rsp_tvalid && rsp_tready) sb.check_result(rsp_tdata, rsp_tuser);
      end
   end

   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready = 0;
      end else begin
         rsp_tready = ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   task automatic push_word(int value, bit last);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid = 0;
         @(negedge clock);
      end
      req_tvalid = 1;
      req_tdata = value;
      req_tlast = last;
      do @(posedge clock); while (!req_tready);
      sent_words++;
   endtask

   task automatic push_frame(int vals[$]);
      foreach (vals[i]) push_word(vals[i], i == vals.size() - 1);
   endtask

   function automatic int random_word();
      int r;
      r = $urandom_range(0, 9);
      if (r < 5) return int'($urandom_range(0, 200)) - 100;
      if (r < 8) return $urandom;
      if (r == 8) return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      return 32'h40000000 + $urandom_range(0, 32'h3fffffff);
   endfunction

   task automatic random_phase(int n_words, int idle, int stall);
      int vals[$];
      int len;
      send_idle_pct = idle;
      recv_stall_pct = stall;
      sent_words = 0;
      while (sent_words < n_words) begin
         vals.delete();
         len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
         repeat (len) vals.push_back(random_word());
         push_frame(vals);
      end
   endtask

   initial begin
      int vals[$];
      sb = new();
      reset = 1;
      req_tvalid = 0;
      req_tdata = 0;
      req_tlast = 0;
      rsp_tready = 0;
      hold_left = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 0;

      push_frame('{32'h7fffffff});
      push_frame('{32'h80000000});
      push_frame('{-5, 7});
      push_frame('{-3, -1, -2});
      push_frame('{0, 0, 0, 0});
      push_frame('{2, -1, 2, -5, 4});
      // Two maxima: the crossing join wraps without any status.
      push_frame('{32'h7fffffff, 32'h7fffffff});
      // The left crossing scan overflows.
      push_frame('{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff});
      push_frame('{32'h80000000, 32'h80000000, 32'h80000000});
      // A store filled exactly, then one word past its size.
      vals.delete();
      repeat (MAX_LEN_DEF) vals.push_back(int'($urandom_range(0, 2000)) - 1000);
      push_frame(vals);
      vals.push_back(55);
      push_frame(vals);

      random_phase(260, 0, 0);
      // Long receiver hold while words keep coming, so the input backs up.
      hold_left = 400;
      random_phase(260, 69, 0);
      random_phase(260, 0, 69);
      random_phase(270, 23, 23);

      @(negedge clock);
      req_tvalid = 0;
      recv_stall_pct = 0;
      while (sb.spans_due.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (sb.errors == 0 && sb.spans_due.size() == 0) $display("ALL CHECKS PASSED");
      else $display("CHECKS FAILED");
      $finish;
   end
endmodule

/* files.f */
+incdir+design
design/msdc_pkg.sv
design/msdc_store.sv
design/msdc_alu.sv
design/msdc_seq.sv
design/max_subarray_divide_conquer_core.sv
tb/max_subarray_divide_conquer_core_test.sv
